// File: hdl/bau_pkg.sv
// ============================================================================
// bau_pkg: shared types and constants for the x86 branch address unfilter
// Payload structs for both channels, the result bundle passed from the
// decoder to the output serializer, and configuration register indexes.
// ============================================================================
`default_nettype none

package bau_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER_BYTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_JCC_ENABLE  = 1'd1;
	localparam int unsigned CFG_DATA_W = 8;

	// Opcode constants
	localparam logic [7:0] OP_TWO_BYTE   = 8'h0F;
	localparam logic [7:0] OP_JCC_LO     = 8'h80;
	localparam logic [7:0] OP_JCC_HI     = 8'h8F;
	localparam logic [7:0] OP_CALL_MASK  = 8'hFE;
	localparam logic [7:0] OP_CALL_JMP   = 8'hE8;

	// Maximum results caused by one input byte
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} bau_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       run_last;
	} bau_out_t;

	// All results of one input byte, handed over as one transaction
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [RES_CNT_W-1:0]    count;
		logic                    last;
	} bau_bundle_t;

endpackage

`default_nettype wire

// File: hdl/bau_core.sv
// ============================================================================
// bau_core: input stage and branch pattern decoder
// Registers the incoming byte, runs the pattern state machine on it and
// produces the bundle of restored bytes that this byte releases.
// ============================================================================
`default_nettype none

module bau_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire bau_pkg::bau_in_t               in_data,
	input  wire logic                           cfg_we,
	input  wire logic [bau_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bau_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                                bnd_valid,
	input  wire logic                           bnd_ready,
	output bau_pkg::bau_bundle_t                bnd
);
	import bau_pkg::*;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_0F   = 7'b0000010,
		PH_0F8  = 7'b0000100,
		PH_E8   = 7'b0001000,
		PH_MARK = 7'b0010000,
		PH_T1   = 7'b0100000,
		PH_T2   = 7'b1000000
	} phase_t;

	// Configuration registers
	logic [7:0] marker_q;
	logic       jcc_q;

	// Input stage
	logic       valid_s1;
	bau_in_t    data_s1;

	// Pattern state
	phase_t      phase_q, phase_n;
	logic [7:0]  hop0_q, hop1_q, htg0_q, htg1_q;
	logic [7:0]  hop0_n, hop1_n, htg0_n, htg1_n;
	logic [31:0] pos_q, pos_n;
	logic [31:0] mpos_q, mpos_n;

	bau_bundle_t res;
	logic        advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= '0;
			jcc_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MARKER_BYTE: marker_q <= cfg_wdata[7:0];
				CFG_JCC_ENABLE:  jcc_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Advance the input stage when its results can be handed on
	assign advance  = valid_s1 && ((res.count == '0) || bnd_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Decode one byte: next state and the bytes it releases
	always_comb begin
		logic [7:0]           b;
		logic [31:0]          disp;
		logic [RES_CNT_W-1:0] n;
		logic [MAX_RES-1:0][7:0] e;
		logic                 fresh;

		b      = data_s1.in_byte;
		disp   = {8'h00, htg0_q, htg1_q, b} - mpos_q;
		n      = '0;
		e      = '0;
		fresh  = 1'b0;
		phase_n = phase_q;
		hop0_n = hop0_q;
		hop1_n = hop1_q;
		htg0_n = htg0_q;
		htg1_n = htg1_q;
		mpos_n = mpos_q;

		case (phase_q)
			PH_0F: begin
				if (b inside {[OP_JCC_LO:OP_JCC_HI]}) begin
					hop1_n  = b;
					phase_n = PH_0F8;
				end else begin
					e[n[RES_IDX_W-1:0]] = hop0_q;
					n = n + RES_CNT_W'(1);
					fresh = 1'b1;
				end
			end
			PH_0F8, PH_E8: begin
				e[n[RES_IDX_W-1:0]] = hop0_q;
				n = n + RES_CNT_W'(1);
				if (phase_q == PH_0F8) begin
					e[n[RES_IDX_W-1:0]] = hop1_q;
					n = n + RES_CNT_W'(1);
				end
				if (b == marker_q) begin
					hop0_n  = b;
					mpos_n  = pos_q + 32'd4;
					phase_n = PH_MARK;
				end else begin
					fresh = 1'b1;
				end
			end
			PH_MARK: begin
				htg0_n  = b;
				phase_n = PH_T1;
			end
			PH_T1: begin
				htg1_n  = b;
				phase_n = PH_T2;
			end
			PH_T2: begin
				e[0] = disp[7:0];
				e[1] = disp[15:8];
				e[2] = disp[23:16];
				e[3] = disp[31:24];
				n = RES_CNT_W'(MAX_RES);
				phase_n = PH_IDLE;
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		// Examine the byte as a possible opcode start
		if (fresh) begin
			if (jcc_q && (b == OP_TWO_BYTE)) begin
				hop0_n  = b;
				phase_n = PH_0F;
			end else if ((b & OP_CALL_MASK) == OP_CALL_JMP) begin
				hop0_n  = b;
				phase_n = PH_E8;
			end else begin
				phase_n = PH_IDLE;
				e[n[RES_IDX_W-1:0]] = b;
				n = n + RES_CNT_W'(1);
			end
		end

		pos_n = pos_q + 32'd1;

		// Flush a pattern cut off by the end of the stream
		if (data_s1.in_last) begin
			case (phase_n)
				PH_0F, PH_E8, PH_MARK: begin
					e[n[RES_IDX_W-1:0]] = hop0_n;
					n = n + RES_CNT_W'(1);
				end
				PH_0F8: begin
					e[n[RES_IDX_W-1:0]] = hop0_n;
					n = n + RES_CNT_W'(1);
					e[n[RES_IDX_W-1:0]] = hop1_n;
					n = n + RES_CNT_W'(1);
				end
				PH_T1: begin
					e[n[RES_IDX_W-1:0]] = hop0_n;
					n = n + RES_CNT_W'(1);
					e[n[RES_IDX_W-1:0]] = htg0_n;
					n = n + RES_CNT_W'(1);
				end
				PH_T2: begin
					e[n[RES_IDX_W-1:0]] = hop0_n;
					n = n + RES_CNT_W'(1);
					e[n[RES_IDX_W-1:0]] = htg0_n;
					n = n + RES_CNT_W'(1);
					e[n[RES_IDX_W-1:0]] = htg1_n;
					n = n + RES_CNT_W'(1);
				end
				default: ;
			endcase
			phase_n = PH_IDLE;
			pos_n   = '0;
		end

		res.bytes = e;
		res.count = n;
		res.last  = data_s1.in_last;
	end

	// Update pattern state control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
		end
	end

	// Hold opcode, target bytes and marker offset
	always_ff @(posedge clk) begin
		if (advance) begin
			hop0_q <= hop0_n;
			hop1_q <= hop1_n;
			htg0_q <= htg0_n;
			htg1_q <= htg1_n;
			mpos_q <= mpos_n;
		end
	end

	assign bnd_valid = valid_s1 && (res.count != '0);
	assign bnd       = res;

endmodule

`default_nettype wire

// File: hdl/bau_serial.sv
// ============================================================================
// bau_serial: result register and output serializer
// Holds one bundle of restored bytes and presents them one per cycle while
// out_ready is high, flagging the last byte of the bundle and of the stream.
// ============================================================================
`default_nettype none

module bau_serial (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 bnd_valid,
	output logic                      bnd_ready,
	input  wire bau_pkg::bau_bundle_t bnd,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bau_pkg::bau_out_t         out_data
);
	import bau_pkg::*;

	bau_bundle_t           bnd_q;
	logic                  valid_q;
	logic [RES_IDX_W-1:0]  idx_q;
	logic                  final_beat;
	logic                  done;

	assign final_beat = ({1'b0, idx_q} == (bnd_q.count - RES_CNT_W'(1)));
	assign done       = valid_q && out_ready && final_beat;
	assign bnd_ready  = !valid_q || done;

	// Load a new bundle, advance through the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (bnd_ready && bnd_valid) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (valid_q && out_ready) begin
			idx_q <= idx_q + RES_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_ready && bnd_valid) begin
			bnd_q <= bnd;
		end
	end

	assign out_valid         = valid_q;
	assign out_data.out_byte = bnd_q.bytes[idx_q];
	assign out_data.run_last = final_beat;
	assign out_data.out_last = final_beat && bnd_q.last;

endmodule

`default_nettype wire

// File: hdl/x86_branch_address_unfilter_unit.sv
// ============================================================================
// x86_branch_address_unfilter_unit: restore x86 call/jump displacements
// Top level: byte decoder followed by the output serializer.
// ============================================================================
// One byte is taken per cycle unless its results wait for the serializer. A
// byte that releases k restored bytes (0 to 4) keeps the output busy for k
// transactions; the output serializer, one transaction per cycle while
// out_ready is high, sets the sustained rate, and the input keeps flowing
// while it drains as long as bytes release nothing. Results pass the input
// and then the result register. Marker and target bytes after E8/E9 (or
// 0F 80..8F with the conditional jump option on) are replaced by the 32-bit
// little-endian displacement; a pattern cut short by in_last comes out
// unchanged, and the position count restarts at zero after the last byte.
`default_nettype none

module x86_branch_address_unfilter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire bau_pkg::bau_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output bau_pkg::bau_out_t                   out_data,
	input  wire logic                           cfg_we,
	input  wire logic [bau_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bau_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bau_pkg::*;

	logic        bnd_valid;
	logic        bnd_ready;
	bau_bundle_t bnd;

	bau_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd)
	);

	bau_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: hdl/bau_checker.sv
// ============================================================================
// bau_checker: port-level checks for the branch address unfilter
// Watches the top level ports and is bound to every instance of it.
// ============================================================================
`default_nettype none

module bau_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire bau_pkg::bau_out_t              out_data
);

	// Stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// End of stream is always the last result of its byte
	a_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_last |-> out_data.run_last)
		else $error("out_last without run_last");

	// A burst of results continues without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.run_last |=> out_valid)
		else $error("gap inside a result burst");

	// With the output drained, input is always taken
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind x86_branch_address_unfilter_unit bau_checker u_bau_checker (.*);

`default_nettype wire

// File: tb/bau_restore_monitor.sv
// ============================================================================
// bau_restore_monitor: scoreboard for the x86 branch address unfilter
// Watches the input, output and register ports. Keeps its own copy of the
// pattern scanner and registers, predicts the restored bytes for every
// accepted input transaction and checks each output transaction in order.
// ============================================================================

module bau_restore_monitor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire bau_pkg::bau_in_t               in_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire bau_pkg::bau_out_t              out_data,
	input  wire logic                           cfg_we,
	input  wire logic [bau_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bau_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int unsigned                         mismatch_count,
	output int unsigned                         bytes_owed
);
	import bau_pkg::*;

	typedef enum logic [2:0] {
		SCAN,
		HOLD_0F,
		HOLD_0F8X,
		HOLD_CALL,
		GOT_MARKER,
		GOT_T1,
		GOT_T2
	} scan_phase_t;

	scan_phase_t phase;
	logic [7:0]  held_op [2];
	logic [7:0]  held_tgt [2];
	logic [31:0] stream_pos;
	logic [31:0] marker_pos;
	logic [7:0]  marker_byte;
	logic        jcc_on;
	logic [7:0]  step_bytes[$];
	bau_out_t    restored_q[$];
	int unsigned fail_tally;

	// Examine a byte with nothing held: start a pattern or pass it through
	task automatic take_fresh(input logic [7:0] b);
		if (jcc_on && b == OP_TWO_BYTE) begin
			held_op[0] = b;
			phase = HOLD_0F;
		end else if ((b & OP_CALL_MASK) == OP_CALL_JMP) begin
			held_op[0] = b;
			phase = HOLD_CALL;
		end else begin
			phase = SCAN;
			step_bytes.push_back(b);
		end
	endtask

	// Advance the scanner by one byte and queue the restored bytes it releases
	task automatic predict_restore(input logic [7:0] b, input logic last);
		logic [31:0] pos;
		logic [31:0] target;
		logic [31:0] disp;
		bau_out_t    item;
		pos = stream_pos;
		step_bytes.delete();
		case (phase)
			HOLD_0F: begin
				if (b >= OP_JCC_LO && b <= OP_JCC_HI) begin
					held_op[1] = b;
					phase = HOLD_0F8X;
				end else begin
					step_bytes.push_back(held_op[0]);
					take_fresh(b);
				end
			end
			HOLD_0F8X, HOLD_CALL: begin
				// opcode bytes go out unchanged whether or not the marker follows
				step_bytes.push_back(held_op[0]);
				if (phase == HOLD_0F8X)
					step_bytes.push_back(held_op[1]);
				if (b == marker_byte) begin
					held_op[0] = b;
					marker_pos = pos;
					phase = GOT_MARKER;
				end else begin
					take_fresh(b);
				end
			end
			GOT_MARKER: begin
				held_tgt[0] = b;
				phase = GOT_T1;
			end
			GOT_T1: begin
				held_tgt[1] = b;
				phase = GOT_T2;
			end
			GOT_T2: begin
				// big-endian absolute target to little-endian relative displacement
				target = {8'h00, held_tgt[0], held_tgt[1], b};
				disp = target - (marker_pos + 32'd4);
				step_bytes.push_back(disp[7:0]);
				step_bytes.push_back(disp[15:8]);
				step_bytes.push_back(disp[23:16]);
				step_bytes.push_back(disp[31:24]);
				phase = SCAN;
			end
			default: take_fresh(b);
		endcase
		stream_pos = pos + 32'd1;

		// flush a pattern cut off by the end of the stream, then restart
		if (last) begin
			case (phase)
				HOLD_0F, HOLD_CALL, GOT_MARKER: step_bytes.push_back(held_op[0]);
				HOLD_0F8X: begin
					step_bytes.push_back(held_op[0]);
					step_bytes.push_back(held_op[1]);
				end
				GOT_T1: begin
					step_bytes.push_back(held_op[0]);
					step_bytes.push_back(held_tgt[0]);
				end
				GOT_T2: begin
					step_bytes.push_back(held_op[0]);
					step_bytes.push_back(held_tgt[0]);
					step_bytes.push_back(held_tgt[1]);
				end
				default: ;
			endcase
			phase = SCAN;
			stream_pos = '0;
		end

		foreach (step_bytes[i]) begin
			item.out_byte = step_bytes[i];
			item.run_last = (i == step_bytes.size() - 1);
			item.out_last = last && item.run_last;
			restored_q.push_back(item);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bau_out_t exp_item;
		if (!arst_n) begin
			phase = SCAN;
			stream_pos = '0;
			marker_pos = '0;
			marker_byte = '0;
			jcc_on = 1'b0;
			restored_q.delete();
			fail_tally = 0;
			mismatch_count <= 0;
			bytes_owed <= 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_MARKER_BYTE: marker_byte = cfg_wdata[7:0];
					CFG_JCC_ENABLE:  jcc_on = cfg_wdata[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				predict_restore(in_data.in_byte, in_data.in_last);

			// compare each output transaction with the oldest expected byte
			if (out_valid && out_ready) begin
				if (restored_q.size() == 0) begin
					fail_tally++;
					$display("%0t: unexpected restored byte %02h (last %b run_last %b)",
						$time, out_data.out_byte, out_data.out_last, out_data.run_last);
				end else begin
					exp_item = restored_q.pop_front();
					if (out_data.out_byte !== exp_item.out_byte ||
						out_data.out_last !== exp_item.out_last ||
						out_data.run_last !== exp_item.run_last) begin
						fail_tally++;
						$display("%0t: expected byte %02h last %b run_last %b, %s",
							$time, exp_item.out_byte, exp_item.out_last,
							exp_item.run_last, "got");
						$display("%0t: got byte %02h last %b run_last %b",
							$time, out_data.out_byte, out_data.out_last,
							out_data.run_last);
					end
				end
			end

			mismatch_count <= fail_tally;
			bytes_owed <= restored_q.size();
		end
	end

endmodule

// File: tb/x86_branch_address_unfilter_unit_test.sv
// ============================================================================
// x86_branch_address_unfilter_unit_test: stimulus and verdict for the unfilter
// Drives byte streams through the block under several register settings:
// a directed set of branch patterns, then random streams that are mostly
// well-formed call/jump patterns with random targets, mixed with broken
// patterns and plain bytes. The sender works in bursts, the receiver stalls
// on its own pattern, and once holds off long enough to fill the block.
// ============================================================================

module x86_branch_address_unfilter_unit_test;

	import bau_pkg::*;

	// Longest correct quiet stretch is the long hold-off
	localparam int unsigned STALL_LIMIT      = 2000;
	localparam int unsigned LONG_HOLD_CYCLES = 150;
	localparam int unsigned DRAIN_CYCLES     = 8;
	localparam int unsigned ITEMS_PER_PHASE  = 40;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	bau_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	bau_out_t              out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int unsigned mismatch_count;
	int unsigned bytes_owed;
	logic        long_hold   = 1'b0;
	int unsigned burst_left  = 0;
	int unsigned byte_count  = 0;
	int unsigned idle_cycles = 0;
	logic [7:0]  stream_q[$];
	logic [7:0]  marker_now  = '0;
	logic        jcc_now     = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	x86_branch_address_unfilter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	bau_restore_monitor restore_mon (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.bytes_owed     (bytes_owed)
	);

	// Bias random bytes toward opcodes, the marker and jcc second bytes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return OP_TWO_BYTE;
			1:       return OP_CALL_JMP | 8'($urandom_range(0, 1));
			2:       return marker_now;
			3:       return OP_JCC_LO | 8'($urandom_range(0, 15));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] marker, input logic jcc);
		marker_now = marker;
		jcc_now = jcc;
		write_reg(CFG_MARKER_BYTE, marker);
		write_reg(CFG_JCC_ENABLE, CFG_DATA_W'(jcc));
	endtask

	// Send the queued bytes in bursts; flag the final one as end of stream if asked
	task automatic send_stream(input logic close);
		int unsigned gap;
		foreach (stream_q[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			in_valid <= 1'b1;
			in_data <= '{in_byte: stream_q[i], in_last: close && (i == stream_q.size() - 1)};
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			byte_count++;
			burst_left--;
		end
	endtask

	// Drop valid and wait until every expected byte is out and the pipe is quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (bytes_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Build one stream of branch patterns, broken patterns and plain bytes
	task automatic random_stream(input int unsigned min_len);
		logic [7:0]  pat[$];
		int unsigned kind;
		int unsigned cut;
		stream_q.delete();
		do begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				pat.delete();
				if (jcc_now && $urandom_range(0, 1)) begin
					pat.push_back(OP_TWO_BYTE);
					pat.push_back(OP_JCC_LO | 8'($urandom_range(0, 15)));
				end else begin
					pat.push_back(OP_CALL_JMP | 8'($urandom_range(0, 1)));
				end
				pat.push_back(marker_now);
				repeat (3) pat.push_back(8'($urandom));
				// break some: truncate or replace the marker
				if (kind >= 6) begin
					if ($urandom_range(0, 1)) begin
						cut = $urandom_range(1, pat.size() - 1);
						while (pat.size() > cut) void'(pat.pop_back());
					end else begin
						pat[pat.size() - 4] = pick_byte();
					end
				end
				foreach (pat[i]) stream_q.push_back(pat[i]);
			end else begin
				repeat ($urandom_range(1, 6)) stream_q.push_back(pick_byte());
			end
		end while (stream_q.size() < min_len || $urandom_range(0, 3) != 0);
		send_stream(1'b1);
	endtask

	// Receiver: ready in segments of differing density, one long hold-off on request
	initial begin
		int unsigned seg_len;
		int unsigned mode;
		bit          hold_done;
		hold_done = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			seg_len = $urandom_range(1, 30);
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				repeat (seg_len) begin
					case (mode)
						0:       out_ready <= 1'b1;
						1:       out_ready <= 1'($urandom_range(0, 1));
						2:       out_ready <= ($urandom_range(0, 4) == 0);
						default: out_ready <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned phase_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: conversions, failed patterns, re-examination, cut-off streams
		set_config(8'hA5, 1'b1);
		stream_q = '{8'hE8, 8'hA5, 8'h12, 8'h34, 8'h56,
			OP_TWO_BYTE, OP_JCC_HI, 8'hA5, 8'hFF, 8'hFF, 8'hFF,
			8'hE9, 8'hE8, 8'hA5, 8'h00};
		send_stream(1'b1);
		stream_q = '{OP_TWO_BYTE, 8'h90, OP_TWO_BYTE, OP_JCC_LO, 8'hFF, OP_TWO_BYTE};
		send_stream(1'b1);
		stream_q = '{8'hE9, 8'hA5, 8'h11, 8'h22};
		send_stream(1'b1);

		// clear jcc with a conditional jump already held
		stream_q = '{OP_TWO_BYTE, 8'h85};
		send_stream(1'b0);
		drain();
		write_reg(CFG_JCC_ENABLE, CFG_DATA_W'(1'b0));
		jcc_now = 1'b0;
		stream_q = '{8'hA5, 8'h00, 8'h00, 8'h10};
		send_stream(1'b1);

		// random streams under several register settings
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0:       set_config(8'h00, 1'b0);
				1:       set_config(8'hFF, 1'b1);
				default: set_config(8'($urandom), 1'($urandom_range(0, 1)));
			endcase
			if (ph == 2) begin
				// long burst while the receiver holds off
				burst_left = 120;
				long_hold <= 1'b1;
				random_stream(120);
			end
			phase_start = byte_count;
			while (byte_count - phase_start < ITEMS_PER_PHASE)
				random_stream(1);
		end

		drain();
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/bau_pkg.sv
hdl/bau_core.sv
hdl/bau_serial.sv
hdl/x86_branch_address_unfilter_unit.sv
hdl/bau_checker.sv
tb/bau_restore_monitor.sv
tb/x86_branch_address_unfilter_unit_test.sv
